// File: design/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
	localparam logic [6:0] LEN_EXT16     = 7'd126;
	localparam logic [6:0] LEN_EXT64     = 7'd127;
	localparam logic [3:0] OPCODE_MASK   = 4'hF;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_ERROR   = 1'b1
	} kind_t;

	// One classified request handed from the parser to the output side.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       frame_end;
	} wsd_item_t;

endpackage

`default_nettype wire

// File: design/wsd_front.sv
// Header parser: walks the frame header and classifies each byte.
`default_nettype none

module wsd_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               byte_valid,
	input  wire [7:0]         link_byte,
	input  wire               queue_full,
	output logic              push,
	output wsd_pkg::wsd_item_t push_item
);
	import wsd_pkg::*;

	typedef enum logic [9:0] {
		PH_HDR0    = 10'b00_0000_0001,
		PH_HDR1    = 10'b00_0000_0010,
		PH_EXT0    = 10'b00_0000_0100,
		PH_EXT1    = 10'b00_0000_1000,
		PH_KEY0    = 10'b00_0001_0000,
		PH_KEY1    = 10'b00_0010_0000,
		PH_KEY2    = 10'b00_0100_0000,
		PH_KEY3    = 10'b00_1000_0000,
		PH_PAYLOAD = 10'b01_0000_0000,
		PH_HALT    = 10'b10_0000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] key_q, key_d;
	logic [15:0] rem_q, rem_d;
	logic [1:0]  idx_q, idx_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic        masked_q, masked_d;
	logic        take;
	logic [6:0]  len_code;
	logic [15:0] ext_len;
	logic [7:0]  key_byte;

	assign take     = byte_valid && !queue_full;
	assign len_code = link_byte[6:0] & LEN_CODE_MASK;
	assign ext_len  = {rem_q[15:8], link_byte};

	// Key byte 0 sits in the top byte of the key.
	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		key_d    = key_q;
		rem_d    = rem_q;
		idx_d    = idx_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		masked_d = masked_q;
		push     = 1'b0;

		push_item.kind      = KIND_PAYLOAD;
		push_item.data      = link_byte;
		push_item.key       = masked_q ? key_byte : 8'h00;
		push_item.opcode    = opcode_q & OPCODE_MASK;
		push_item.fin       = fin_q;
		push_item.frame_end = (rem_q == 16'd1);

		if (take) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_d    = link_byte[7];
					opcode_d = link_byte[3:0] & OPCODE_MASK;
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = link_byte[7];
					if (len_code == LEN_EXT64) begin
						// Too long to carry: report once, then halt.
						phase_d             = PH_HALT;
						push                = 1'b1;
						push_item.kind      = KIND_ERROR;
						push_item.data      = 8'h00;
						push_item.key       = 8'h00;
						push_item.frame_end = 1'b0;
					end else if (len_code == LEN_EXT16) begin
						rem_d   = 16'h0000;
						phase_d = PH_EXT0;
					end else begin
						rem_d = {9'd0, len_code};
						if (link_byte[7]) begin
							key_d   = 32'h0000_0000;
							phase_d = PH_KEY0;
						end else begin
							idx_d   = 2'd0;
							phase_d = (len_code == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
						end
					end
				end
				PH_EXT0: begin
					rem_d   = {link_byte, 8'h00};
					phase_d = PH_EXT1;
				end
				PH_EXT1: begin
					rem_d = ext_len;
					if (masked_q) begin
						key_d   = 32'h0000_0000;
						phase_d = PH_KEY0;
					end else begin
						idx_d   = 2'd0;
						phase_d = (ext_len == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
					end
				end
				PH_KEY0: begin
					key_d[31:24] = link_byte;
					phase_d      = PH_KEY1;
				end
				PH_KEY1: begin
					key_d[23:16] = link_byte;
					phase_d      = PH_KEY2;
				end
				PH_KEY2: begin
					key_d[15:8] = link_byte;
					phase_d     = PH_KEY3;
				end
				PH_KEY3: begin
					// Key is consumed even for an empty frame.
					key_d[7:0] = link_byte;
					idx_d      = 2'd0;
					phase_d    = (rem_q == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					push  = 1'b1;
					idx_d = idx_q + 2'd1;
					rem_d = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						phase_d = PH_HDR0;
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			key_q    <= 32'h0000_0000;
			rem_q    <= 16'h0000;
			idx_q    <= 2'd0;
			opcode_q <= 4'd0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			idx_q    <= idx_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			masked_q <= masked_d;
		end
	end

endmodule

`default_nettype wire

// File: design/wsd_queue.sv
// Short request queue between the parser and the output stage.
`default_nettype none

module wsd_queue #(
	parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wsd_pkg::wsd_item_t push_item,
	input  wire                pop,
	output wsd_pkg::wsd_item_t head_item,
	output logic               not_empty,
	output logic               full
);
	import wsd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsd_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/wsd_back.sv
// Output stage: unmasks the head request and holds the result register.
`default_nettype none

module wsd_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wsd_pkg::wsd_item_t head_item,
	input  wire                head_valid,
	output logic               pop,
	output logic               result_valid,
	input  wire                result_stall,
	output logic               kind,
	output logic [7:0]         payload_byte,
	output logic [3:0]         frame_opcode,
	output logic               final_fragment,
	output logic               frame_end
);
	import wsd_pkg::*;

	logic       valid_q;
	logic       kind_q;
	logic [7:0] data_q;
	logic [3:0] opcode_q;
	logic       fin_q;
	logic       end_q;

	// Refill whenever the register is empty or being drained.
	assign pop = head_valid && (!valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head_item.kind;
			data_q   <= head_item.data ^ head_item.key;
			opcode_q <= head_item.opcode;
			fin_q    <= head_item.fin;
			end_q    <= head_item.frame_end;
		end
	end

	assign result_valid   = valid_q;
	assign kind           = kind_q;
	assign payload_byte   = data_q;
	assign frame_opcode   = opcode_q;
	assign final_fragment = fin_q;
	assign frame_end      = end_q;

endmodule

`default_nettype wire

// File: design/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: parser, request queue and output stage.
`default_nettype none

// Receives a WebSocket byte stream one byte per request on link_byte and returns
// one result per payload byte, unmasked with the frame's key, tagged with the
// frame's opcode, FIN bit and an end-of-frame mark. Header, extended length and
// mask key bytes give no result; a frame of zero length gives none at all, though
// its key bytes are still consumed. A length code of 127 gives a single error
// result (kind 1, payload_byte 0, frame_end 0) after which every byte is taken
// and dropped until reset. Throughput is one byte per cycle in and one result per
// cycle out: the header parser takes a byte each cycle while the request queue
// (QUEUE_DEPTH entries) has room, and the output register refills each cycle it
// is drained. An accepted payload byte is written into the request queue and then
// into the output register before it appears on the result port. byte_stall rises
// only once result_stall has held the output long enough to fill the queue.
module websocket_frame_deframer_core #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_stall,
	input  wire  [7:0] link_byte,
	output logic       result_valid,
	input  wire        result_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic       frame_end
);
	import wsd_pkg::*;

	wsd_item_t push_item;
	wsd_item_t head_item;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_not_empty;

	// Hold the byte side off only while the queue is full.
	assign byte_stall = q_full;

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.link_byte  (link_byte),
		.queue_full (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	wsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_item      (head_item),
		.head_valid     (q_not_empty),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.frame_opcode   (frame_opcode),
		.final_fragment (final_fragment),
		.frame_end      (frame_end)
	);

	// The parser must never offer a request to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("request pushed into a full queue");

	// An error is the last result ever: nothing follows it until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && kind == KIND_ERROR) |=> !result_valid)
		else $error("result delivered after an error");

	// Error results never carry the end-of-frame mark or data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_ERROR) |-> (!frame_end && payload_byte == 8'h00))
		else $error("malformed error result");

	// Popping needs a request at the head of the queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_not_empty)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: bench/websocket_deframer_checker.sv
// Watches both channels of the deframer, predicts each result and compares it.
`timescale 1ns / 100ps

module websocket_deframer_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	input  wire        byte_stall,
	input  wire  [7:0] link_byte,
	input  wire        result_valid,
	input  wire        result_stall,
	input  wire        kind,
	input  wire  [7:0] payload_byte,
	input  wire  [3:0] frame_opcode,
	input  wire        final_fragment,
	input  wire        frame_end,
	output int         mismatches,
	output int         outstanding
);
	import wsd_pkg::*;

	typedef enum logic [3:0] {
		AWAIT_HEAD,
		AWAIT_LENGTH,
		EXT_HIGH,
		EXT_LOW,
		KEY_0,
		KEY_1,
		KEY_2,
		KEY_3,
		IN_PAYLOAD,
		HALTED
	} parse_phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} deframed_t;

	parse_phase_t phase;
	logic [31:0]  key;
	logic [15:0]  bytes_left;
	logic [1:0]   key_idx;
	logic [3:0]   opcode;
	logic         fin;
	logic         masked;
	deframed_t    due_q[$];

	// Start the payload, or drop an empty frame and go back to the header.
	task automatic begin_payload();
		key_idx = 2'd0;
		phase = (bytes_left == 16'd0) ? AWAIT_HEAD : IN_PAYLOAD;
	endtask

	task automatic end_of_length();
		if (masked) begin
			key = '0;
			phase = KEY_0;
		end else begin
			begin_payload();
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] key_byte;
		deframed_t  r;
		case (phase)
		AWAIT_HEAD: begin
			fin = b[7];
			opcode = b[3:0] & OPCODE_MASK;
			phase = AWAIT_LENGTH;
		end
		AWAIT_LENGTH: begin
			masked = b[7];
			if (b[6:0] == LEN_EXT64) begin
				phase = HALTED;
				r = '{KIND_ERROR, 8'h00, opcode, fin, 1'b0};
				due_q.push_back(r);
			end else if (b[6:0] == LEN_EXT16) begin
				bytes_left = '0;
				phase = EXT_HIGH;
			end else begin
				bytes_left = {9'd0, b[6:0]};
				end_of_length();
			end
		end
		EXT_HIGH: begin
			bytes_left = {b, 8'h00};
			phase = EXT_LOW;
		end
		EXT_LOW: begin
			bytes_left = {bytes_left[15:8], b};
			end_of_length();
		end
		KEY_0, KEY_1, KEY_2, KEY_3: begin
			// shift in: the first key byte ends up in the top byte
			key = {key[23:0], b};
			if (phase == KEY_3)
				begin_payload();
			else
				phase = parse_phase_t'(phase + 4'd1);
		end
		IN_PAYLOAD: begin
			key_byte = masked ? key[31 - 8 * int'(key_idx) -: 8] : 8'h00;
			key_idx = key_idx + 2'd1;
			bytes_left = bytes_left - 16'd1;
			r = '{KIND_PAYLOAD, b ^ key_byte, opcode, fin, bytes_left == 16'd0};
			due_q.push_back(r);
			if (bytes_left == 16'd0)
				phase = AWAIT_HEAD;
		end
		default: phase = HALTED;
		endcase
	endtask

	task automatic check_result();
		deframed_t want;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result kind %0d byte %02h op %0d fin %0d end %0d",
					$realtime, kind, payload_byte, frame_opcode, final_fragment, frame_end);
		end else begin
			want = due_q.pop_front();
			if (kind !== want.kind || payload_byte !== want.data
					|| frame_opcode !== want.opcode || final_fragment !== want.fin
					|| frame_end !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected kind %0d byte %02h op %0d fin %0d end %0d, %s",
						$realtime, want.kind, want.data, want.opcode, want.fin, want.last,
						$sformatf("got kind %0d byte %02h op %0d fin %0d end %0d",
							kind, payload_byte, frame_opcode, final_fragment, frame_end));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = AWAIT_HEAD;
			key = '0;
			bytes_left = '0;
			key_idx = '0;
			opcode = '0;
			fin = 1'b0;
			masked = 1'b0;
			due_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			if (byte_valid && !byte_stall)
				deframe_byte(link_byte);
			outstanding = due_q.size();
		end
	end

endmodule

// File: bench/websocket_frame_deframer_core_tb.sv
// Testbench top of the WebSocket frame deframer: stimulus, idling and verdict.
`timescale 1ns / 100ps

module websocket_frame_deframer_core_tb;
	import wsd_pkg::*;

	// Opcodes used to build header bytes; the reserved ones go through untouched.
	localparam logic [3:0] OP_CONT      = 4'h0;
	localparam logic [3:0] OP_TEXT      = 4'h1;
	localparam logic [3:0] OP_BINARY    = 4'h2;
	localparam logic [3:0] OP_RSVD_DATA = 4'h3;
	localparam logic [3:0] OP_CLOSE     = 4'h8;
	localparam logic [3:0] OP_PING      = 4'h9;
	localparam logic [3:0] OP_PONG      = 4'hA;
	localparam logic [3:0] OP_RSVD_CTRL = 4'hF;

	// at least this many bytes are sent before the closing over-long frame
	localparam int TOTAL_BYTES  = 1700;
	localparam int IDLE_PERCENT = 26;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic [7:0] link_byte    = 8'h00;
	logic       result_stall = 1'b0;
	// high during the stretch where neither side idles
	logic       calm         = 1'b0;

	logic       byte_stall;
	logic       result_valid;
	logic       kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       final_fragment;
	logic       frame_end;

	int failures;
	int outstanding;
	int link_bytes_sent;

	websocket_frame_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.link_byte     (link_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.frame_opcode  (frame_opcode),
		.final_fragment(final_fragment),
		.frame_end     (frame_end)
	);

	websocket_deframer_checker deframe_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.link_byte     (link_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.frame_opcode  (frame_opcode),
		.final_fragment(final_fragment),
		.frame_end     (frame_end),
		.mismatches    (failures),
		.outstanding   (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the result side at random, except during the calm stretch.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Offer one byte as a request and hold it until it is taken. Called and
	// returning at a rising edge. Stall is looked at on the falling edge, where
	// every input and output is settled, so the acceptance edge is the next
	// rising one.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		link_byte  <= b;
		@(negedge clk);
		while (byte_stall)
			@(negedge clk);
		@(posedge clk);
		link_bytes_sent++;
	endtask

	// Send a whole frame: header, length (short or 16-bit extended form),
	// mask key when masked, then random payload bytes.
	task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
			input logic masked, input int length, input bit long_form,
			input logic [31:0] key);
		send_byte({fin, rsv, op});
		if (long_form || length > 125) begin
			send_byte({masked, LEN_EXT16});
			send_byte(length[15:8]);
			send_byte(length[7:0]);
		end else begin
			send_byte({masked, length[6:0]});
		end
		if (masked)
			for (int i = 0; i < 4; i++)
				send_byte(key[31 - 8 * i -: 8]);
		for (int i = 0; i < length; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned pick;
		int          len;
		bit          lf;

		link_bytes_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: each opcode class, both length forms at their edges,
		// empty frames with and without a key, reserved opcodes with RSV bits set.
		send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 1, 1'b0, 32'h0);
		send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 5, 1'b0, 32'hFF00A55A);
		send_frame(1'b1, 3'b000, OP_PING, 1'b0, 0, 1'b0, 32'h0);
		// empty masked frame: the key bytes must still be swallowed
		send_frame(1'b1, 3'b000, OP_PONG, 1'b1, 0, 1'b0, 32'h12345678);
		send_frame(1'b0, 3'b000, OP_CONT, 1'b1, 125, 1'b0, 32'hFFFFFFFF);
		send_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, 2, 1'b0, 32'h00000000);
		send_frame(1'b0, 3'b000, OP_BINARY, 1'b0, 126, 1'b1, 32'h0);
		send_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 0, 1'b1, 32'hDEADBEEF);
		send_frame(1'b0, 3'b000, OP_TEXT, 1'b1, 3, 1'b1, 32'hA5A5A5A5);
		send_frame(1'b0, 3'b111, OP_RSVD_DATA, 1'b0, 4, 1'b0, 32'h0);
		send_frame(1'b0, 3'b111, OP_RSVD_CTRL, 1'b1, 6, 1'b0, 32'h0F0F0F0F);
		send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 300, 1'b1, $urandom());

		// Random frames until the byte budget is spent: every header bit random,
		// lengths mostly short, a few empty, a few in the extended form, and a
		// calm stretch in the middle.
		while (link_bytes_sent < TOTAL_BYTES) begin
			calm <= (link_bytes_sent >= 700 && link_bytes_sent < 1100);
			pick = $urandom_range(0, 99);
			lf = 1'b0;
			if (pick < 8) begin
				len = 0;
				lf = 1'($urandom_range(0, 1));
			end else if (pick < 18) begin
				len = $urandom_range(0, 300);
				lf = 1'b1;
			end else if (pick < 22) begin
				len = 125;
			end else begin
				len = $urandom_range(1, 40);
			end
			send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), len, lf, $urandom());
		end
		calm <= 1'b0;

		// Close with an over-long frame: one error result, then the block halts
		// and must drop every further byte without a word.
		send_byte({1'b1, 3'b000, OP_BINARY});
		send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
		repeat (20)
			send_byte(8'($urandom_range(0, 255)));
		byte_valid <= 1'b0;

		// Drain: wait for every expected result, then let the pipeline settle.
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer_core.sv
bench/websocket_deframer_checker.sv
bench/websocket_frame_deframer_core_tb.sv
